// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TNS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define TNS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/tns_pkg.sv =====
// Types and constants of the top-N score selector.
`timescale 1ns / 1ps
package tns_pkg;

  localparam int SCORE_W = 32;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 4;
  localparam logic [CFG_W-1:0] TOP_COUNT_RST = 4'd5;

  typedef struct packed {
    logic                      vld;
    logic signed [SCORE_W-1:0] score;
    logic [IDX_W-1:0]          idx;
  } tns_entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } tns_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } tns_state_t;

endpackage

// ===== sv/tns_in_if.sv =====
// Input channel: one score word per handshake.
`timescale 1ns / 1ps
interface tns_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [tns_pkg::SCORE_W-1:0] score;
  logic                               vector_end;

  modport source (output valid, output score, output vector_end, input ready);
  modport sink   (input valid, input score, input vector_end, output ready);
endinterface

// ===== sv/tns_out_if.sv =====
// Result channel: one selected entry per handshake.
`timescale 1ns / 1ps
interface tns_out_if;
  logic                               valid;
  logic                               ready;
  logic [tns_pkg::IDX_W-1:0]          class_index;
  logic signed [tns_pkg::SCORE_W-1:0] class_score;
  logic                               run_last;

  modport source (output valid, output class_index, output class_score,
                  output run_last, input ready);
  modport sink   (input valid, input class_index, input class_score,
                  input run_last, output ready);
endinterface

// ===== sv/tns_cell.sv =====
// One compare-and-shift cell of the sorted score chain.
`timescale 1ns / 1ps
module tns_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tns_pkg::tns_ctrl_t                 ctrl,
  input  logic signed [tns_pkg::SCORE_W-1:0] in_score,
  input  logic [tns_pkg::IDX_W-1:0]          in_idx,
  input  tns_pkg::tns_entry_t                left_ent,
  input  logic                               left_ins,
  input  tns_pkg::tns_entry_t                right_ent,
  output tns_pkg::tns_entry_t                ent,
  output logic                               ins
);
  import tns_pkg::*;

  logic                      vld_r, vld_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;

  // strict compare: a new score goes behind equal kept scores
  assign ins = !vld_r || (in_score > score_r);

  always_comb begin
    vld_nxt   = vld_r;
    score_nxt = score_r;
    idx_nxt   = idx_r;
    if (ctrl.clear) begin
      vld_nxt = 1'b0;
    end else if (ctrl.insert) begin
      if (ins) begin
        if (left_ins) begin
          vld_nxt   = left_ent.vld;
          score_nxt = left_ent.score;
          idx_nxt   = left_ent.idx;
        end else begin
          vld_nxt   = 1'b1;
          score_nxt = in_score;
          idx_nxt   = in_idx;
        end
      end
    end else if (ctrl.shift) begin
      vld_nxt   = right_ent.vld;
      score_nxt = right_ent.score;
      idx_nxt   = right_ent.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    idx_r   <= idx_nxt;
  end

  assign ent.vld   = vld_r;
  assign ent.score = score_r;
  assign ent.idx   = idx_r;

endmodule

// ===== sv/top_n_score_selector.sv =====
// Top level of the top-N score selector: control and the cell chain.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Scores of a vector stream in one word per cycle; each is numbered by its
// position and inserted into a chain of MAX_TOP compare cells in the cycle it
// is accepted, so collection runs at one score per clock. Equal scores keep
// arrival order. The word flagged vector_end is inserted too, then input
// ready drops and the chain shifts out min(kept, N) entries, highest first,
// one per accepted output word, run_last on the final one. N is top_count
// clamped to 1..MAX_TOP, sampled at vector end; scores past MAX_CLASSES are
// dropped. Write cfg only while idle.
module top_n_score_selector #(
  parameter int MAX_TOP     = 8,
  parameter int MAX_CLASSES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tns_in_if.sink                     in_ch,
  tns_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [tns_pkg::CFG_W-1:0]  cfg_wdata
);
  import tns_pkg::*;

  localparam int KW = $clog2(MAX_TOP + 1);
  localparam int PW = $clog2(MAX_CLASSES + 1);

  tns_state_t        state_r, state_nxt;
  logic [KW-1:0]     kept_r, kept_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [KW-1:0]     rem_r, rem_nxt;
  logic [CFG_W-1:0]  top_cfg_r, top_cfg_nxt;

  logic              acc_in, acc_out, do_ins;
  logic [KW-1:0]     n_clamp;
  logic [PW+IDX_W-1:0] pos_ext;
  tns_ctrl_t         ctrl;

  tns_entry_t        ent [MAX_TOP];
  logic              ins [MAX_TOP];
  logic [MAX_TOP-1:0] vld_vec;

  assign acc_in  = in_ch.valid && in_ch.ready;
  assign acc_out = out_ch.valid && out_ch.ready;
  assign do_ins  = acc_in && (pos_r < PW'(MAX_CLASSES));
  assign pos_ext = {{IDX_W{1'b0}}, pos_r};

  always_comb begin
    if (top_cfg_r == '0) begin
      n_clamp = KW'(1);
    end else if (int'(top_cfg_r) > MAX_TOP) begin
      n_clamp = KW'(MAX_TOP);
    end else begin
      n_clamp = KW'(top_cfg_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_in && in_ch.vector_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_out && rem_r == KW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready  = 1'b1;
      ST_DRAIN: out_ch.valid = 1'b1;
      default: begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
      end
    endcase
  end

  assign ctrl.insert = do_ins;
  assign ctrl.shift  = acc_out;
  assign ctrl.clear  = acc_out && (rem_r == KW'(1));

  assign out_ch.class_index = ent[0].idx;
  assign out_ch.class_score = ent[0].score;
  assign out_ch.run_last    = (rem_r == KW'(1));

  always_comb begin
    kept_nxt    = kept_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    top_cfg_nxt = cfg_we ? cfg_wdata : top_cfg_r;
    if (do_ins) begin
      pos_nxt = pos_r + PW'(1);
      if (kept_r < KW'(MAX_TOP)) begin
        kept_nxt = kept_r + KW'(1);
      end
    end
    if (acc_in && in_ch.vector_end) begin
      rem_nxt = (kept_nxt < n_clamp) ? kept_nxt : n_clamp;
    end
    if (acc_out) begin
      rem_nxt = rem_r - KW'(1);
      if (rem_r == KW'(1)) begin
        kept_nxt = '0;
        pos_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      kept_r    <= '0;
      pos_r     <= '0;
      rem_r     <= '0;
      top_cfg_r <= TOP_COUNT_RST;
    end else begin
      state_r   <= state_nxt;
      kept_r    <= kept_nxt;
      pos_r     <= pos_nxt;
      rem_r     <= rem_nxt;
      top_cfg_r <= top_cfg_nxt;
    end
  end

  // cell chain, cell 0 holds the highest score
  for (genvar g = 0; g < MAX_TOP; g++) begin : g_cell
    tns_entry_t left_ent, right_ent;
    logic       left_ins;

    if (g == 0) begin : g_head
      assign left_ent = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[g-1];
      assign left_ins = ins[g-1];
    end

    if (g == MAX_TOP - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ent[g+1];
    end

    tns_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .in_score  (in_ch.score),
      .in_idx    (pos_ext[IDX_W-1:0]),
      .left_ent  (left_ent),
      .left_ins  (left_ins),
      .right_ent (right_ent),
      .ent       (ent[g]),
      .ins       (ins[g])
    );

    assign vld_vec[g] = ent[g].vld;
  end

  `TNS_ASSERT_ALWAYS(a_no_overlap, !(in_ch.ready && out_ch.valid))
  `TNS_ASSERT(a_kept_matches_cells,
    (state_r == ST_IDLE) |-> (int'(kept_r) == $countones(vld_vec)))
  `TNS_ASSERT(a_drain_nonempty, (state_r == ST_DRAIN) |-> (rem_r != '0 && rem_r <= kept_r))
  `TNS_ASSERT(a_clear_after_run,
    (acc_out && out_ch.run_last) |=> (kept_r == '0 && pos_r == '0 && state_r == ST_IDLE))

endmodule
